// File: rtl/hncr_pkg.sv
// Shared constants, codes and tables for the numeric character reference decoder.
`timescale 1ns / 1ps

package hncr_pkg;

	localparam int CP_W = 21;
	localparam int STATUS_W = 3;
	localparam int DIGIT_W = 4;
	localparam int MUL_W = CP_W + 4;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REMAPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DISALLOWED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_NUMERIC = 3'd5;
	localparam logic [STATUS_W-1:0] ST_STOP = 3'd6;

	localparam logic [0:0] REG_EXTRA_STOP_ENABLE = 1'd0;
	localparam logic [0:0] REG_EXTRA_STOP_CHAR = 1'd1;

	localparam logic [CP_W-1:0] CP_TAB = 21'h00009;
	localparam logic [CP_W-1:0] CP_LF = 21'h0000A;
	localparam logic [CP_W-1:0] CP_FF = 21'h0000C;
	localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
	localparam logic [CP_W-1:0] CP_LT = 21'h0003C;
	localparam logic [CP_W-1:0] CP_AMP = 21'h00026;
	localparam logic [CP_W-1:0] CP_HASH = 21'h00023;
	localparam logic [CP_W-1:0] CP_SEMI = 21'h0003B;
	localparam logic [CP_W-1:0] CP_LOWER_X = 21'h00078;
	localparam logic [CP_W-1:0] CP_UPPER_X = 21'h00058;
	localparam logic [CP_W-1:0] CP_DIGIT_0 = 21'h00030;
	localparam logic [CP_W-1:0] CP_DIGIT_9 = 21'h00039;
	localparam logic [CP_W-1:0] CP_LOWER_A = 21'h00061;
	localparam logic [CP_W-1:0] CP_LOWER_F = 21'h00066;
	localparam logic [CP_W-1:0] CP_UPPER_A = 21'h00041;
	localparam logic [CP_W-1:0] CP_UPPER_F = 21'h00046;
	localparam logic [CP_W-1:0] CP_SURR_LO = 21'h0D800;
	localparam logic [CP_W-1:0] CP_SURR_HI = 21'h0DFFF;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h0FFFD;
	localparam logic [CP_W-1:0] CP_NONCHAR_LO = 21'h0FDD0;
	localparam logic [CP_W-1:0] CP_NONCHAR_HI = 21'h0FDEF;
	localparam logic [CP_W-1:0] CP_NONCHAR_MASK = 21'h0FFFE;
	localparam logic [CP_W-1:0] CP_DEL = 21'h0007F;
	localparam logic [CP_W-1:0] CP_C1_HI = 21'h0009F;
	localparam logic [CP_W-1:0] ACC_SAT = 21'h110000;

	localparam int REMAP_TABLE_SIZE = 28;

	localparam logic [0:REMAP_TABLE_SIZE-1][7:0] REMAP_FROM = {
		8'h00, 8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
		8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
		8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
	};

	localparam logic [0:REMAP_TABLE_SIZE-1][15:0] REMAP_TO = {
		16'hFFFD, 16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020,
		16'h2021, 16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D,
		16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
	};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CP_W-1:0] char_out;
		logic given_back;
		logic missing_semicolon;
	} result_t;

endpackage

// File: rtl/html_numeric_char_ref_decoder_top.sv
// Top level of the HTML numeric character reference decoder.
`timescale 1ns / 1ps

// The block takes one code point per beat, starting with the one after the ampersand, and
// accepts a new beat every cycle; a beat whose result waits on a stalled output is held in the
// input register until the output register frees. The beat that ends the reference is taken
// into the input register, where the shift-add accumulate and the end-of-number checks run,
// and its result then into the result register. The figure of one beat per cycle is set by
// that single accumulate step, a constant multiply by ten or sixteen built from shifts and
// one add. There is no clearing pass after reset.
module html_numeric_char_ref_decoder_top #(
	parameter int REMAP_ENTRIES = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_addr,
	input  logic [20:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // code_point [20:0], zero fill [23:21]
	input  logic        s_tlast,  // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // char_out [20:0], given_back [21], missing_semicolon [22]
	output logic [2:0]  m_tuser   // status [2:0]
);

	localparam int USED_ENTRIES = (REMAP_ENTRIES < hncr_pkg::REMAP_TABLE_SIZE) ?
		REMAP_ENTRIES : hncr_pkg::REMAP_TABLE_SIZE;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_HASH = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;

	logic extra_stop_enable_q;
	logic [hncr_pkg::CP_W-1:0] extra_stop_char_q;

	logic valid_s1;
	logic [hncr_pkg::CP_W-1:0] cp_s1;
	logic eoi_s1;

	logic [1:0] phase_q;
	logic hex_q;
	logic [hncr_pkg::CP_W-1:0] accum_q;
	logic seen_q;

	logic out_valid_q;
	hncr_pkg::result_t out_q;

	logic advance;
	logic has_res;
	hncr_pkg::result_t res;
	logic [1:0] phase_d;
	logic hex_d;
	logic [hncr_pkg::CP_W-1:0] accum_d;
	logic seen_d;

	logic hex_eff;
	logic is_dec;
	logic is_hex_lc;
	logic is_hex_uc;
	logic is_digit;
	logic [hncr_pkg::DIGIT_W-1:0] digit;
	logic [hncr_pkg::MUL_W-1:0] scaled;
	logic [hncr_pkg::MUL_W-1:0] nv;
	logic [hncr_pkg::CP_W-1:0] accum_next;
	logic remap_hit;
	logic [hncr_pkg::CP_W-1:0] remap_val;
	logic gb;
	hncr_pkg::result_t fin;

	function automatic logic is_disallowed(input logic [hncr_pkg::CP_W-1:0] v);
		logic r;
		r = 1'b0;
		if (v >= 21'h00001 && v <= 21'h00008) r = 1'b1;
		if (v == 21'h0000B) r = 1'b1;
		if (v >= 21'h0000E && v <= 21'h0001F) r = 1'b1;
		if (v >= hncr_pkg::CP_DEL && v <= hncr_pkg::CP_C1_HI) r = 1'b1;
		if (v >= hncr_pkg::CP_NONCHAR_LO && v <= hncr_pkg::CP_NONCHAR_HI) r = 1'b1;
		if ((v & hncr_pkg::CP_NONCHAR_MASK) == hncr_pkg::CP_NONCHAR_MASK) r = 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_stop_enable_q <= 1'b0;
			extra_stop_char_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				hncr_pkg::REG_EXTRA_STOP_ENABLE: extra_stop_enable_q <= cfg_wdata[0];
				hncr_pkg::REG_EXTRA_STOP_CHAR: extra_stop_char_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Digit decoding for the current base; right after '#' the base is decimal.
	always_comb begin
		hex_eff = (phase_q == PH_DIGITS) ? hex_q : 1'b0;
		is_dec = !eoi_s1 && cp_s1 >= hncr_pkg::CP_DIGIT_0 && cp_s1 <= hncr_pkg::CP_DIGIT_9;
		is_hex_lc = !eoi_s1 && hex_eff &&
			cp_s1 >= hncr_pkg::CP_LOWER_A && cp_s1 <= hncr_pkg::CP_LOWER_F;
		is_hex_uc = !eoi_s1 && hex_eff &&
			cp_s1 >= hncr_pkg::CP_UPPER_A && cp_s1 <= hncr_pkg::CP_UPPER_F;
		is_digit = is_dec || is_hex_lc || is_hex_uc;
		digit = is_dec ? cp_s1[3:0] : cp_s1[3:0] + 4'd9;
		scaled = hex_eff ? {accum_q, 4'b0000} :
			({1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0});
		nv = scaled + hncr_pkg::MUL_W'(digit);
		accum_next = (accum_q >= hncr_pkg::ACC_SAT ||
			nv >= hncr_pkg::MUL_W'(hncr_pkg::ACC_SAT)) ? hncr_pkg::ACC_SAT :
			nv[hncr_pkg::CP_W-1:0];
	end

	// Classification of the finished number.
	always_comb begin
		remap_hit = 1'b0;
		remap_val = '0;
		for (int i = 0; i < USED_ENTRIES; i++) begin
			if (!remap_hit && accum_q == hncr_pkg::CP_W'(hncr_pkg::REMAP_FROM[i])) begin
				remap_hit = 1'b1;
				remap_val = hncr_pkg::CP_W'(hncr_pkg::REMAP_TO[i]);
			end
		end
		gb = eoi_s1 || cp_s1 != hncr_pkg::CP_SEMI;
		fin.given_back = gb;
		fin.missing_semicolon = gb;
		if (remap_hit) begin
			fin.status = hncr_pkg::ST_REMAPPED;
			fin.char_out = remap_val;
		end else if ((accum_q >= hncr_pkg::CP_SURR_LO && accum_q <= hncr_pkg::CP_SURR_HI) ||
			accum_q > hncr_pkg::CP_MAX) begin
			fin.status = hncr_pkg::ST_REPLACED;
			fin.char_out = hncr_pkg::CP_REPLACEMENT;
		end else if (is_disallowed(accum_q)) begin
			fin.status = hncr_pkg::ST_DISALLOWED;
			fin.char_out = accum_q;
		end else begin
			fin.status = hncr_pkg::ST_OK;
			fin.char_out = accum_q;
		end
	end

	always_comb begin
		has_res = 1'b0;
		res.status = hncr_pkg::ST_STOP;
		res.char_out = '0;
		res.given_back = 1'b1;
		res.missing_semicolon = 1'b0;
		phase_d = phase_q;
		hex_d = hex_q;
		accum_d = accum_q;
		seen_d = seen_q;
		unique case (phase_q) inside
			PH_HASH, PH_DIGITS: begin
				if (phase_q == PH_HASH && !eoi_s1 &&
					(cp_s1 == hncr_pkg::CP_LOWER_X || cp_s1 == hncr_pkg::CP_UPPER_X)) begin
					hex_d = 1'b1;
					phase_d = PH_DIGITS;
				end else if (is_digit) begin
					hex_d = hex_eff;
					accum_d = accum_next;
					seen_d = 1'b1;
					phase_d = PH_DIGITS;
				end else begin
					has_res = 1'b1;
					if (!seen_q) begin
						res.status = hncr_pkg::ST_NO_DIGITS;
					end else begin
						res = fin;
					end
				end
			end
			default: begin
				if (eoi_s1 || (extra_stop_enable_q && cp_s1 == extra_stop_char_q) ||
					cp_s1 == hncr_pkg::CP_TAB || cp_s1 == hncr_pkg::CP_LF ||
					cp_s1 == hncr_pkg::CP_FF || cp_s1 == hncr_pkg::CP_SPACE ||
					cp_s1 == hncr_pkg::CP_LT || cp_s1 == hncr_pkg::CP_AMP) begin
					has_res = 1'b1;
				end else if (cp_s1 == hncr_pkg::CP_HASH) begin
					phase_d = PH_HASH;
					hex_d = 1'b0;
					accum_d = '0;
					seen_d = 1'b0;
				end else begin
					has_res = 1'b1;
					res.status = hncr_pkg::ST_NOT_NUMERIC;
				end
			end
		endcase
		if (has_res) begin
			phase_d = PH_START;
			hex_d = 1'b0;
			accum_d = '0;
			seen_d = 1'b0;
		end
	end

	assign advance = valid_s1 && (!has_res || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cp_s1 <= s_tdata[hncr_pkg::CP_W-1:0];
			eoi_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			hex_q <= 1'b0;
			accum_q <= '0;
			seen_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			hex_q <= hex_d;
			accum_q <= accum_d;
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.status;
	assign m_tdata = {1'b0, out_q.missing_semicolon, out_q.given_back, out_q.char_out};

endmodule

// File: rtl/hncr_checker.sv
// Port-level checker for the numeric character reference decoder, bound to the top level.
`timescale 1ns / 1ps

module hncr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A stalled result beat keeps its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 3'd7)
		else $error("status code out of range");

	// Results without a character carry no code point and always give the item back.
	a_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser >= hncr_pkg::ST_NO_DIGITS |->
		m_tdata[20:0] == 21'd0 && m_tdata[21] && !m_tdata[22])
		else $error("non-character result has wrong fields");

	// A finished number flags a missing semicolon exactly when its terminator returns; a replaced one carries U+FFFD.
	a_semicolon: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser <= hncr_pkg::ST_DISALLOWED |-> m_tdata[22] == m_tdata[21] &&
		(m_tuser != hncr_pkg::ST_REPLACED || m_tdata[20:0] == hncr_pkg::CP_REPLACEMENT))
		else $error("finished number has inconsistent flags");

endmodule

bind html_numeric_char_ref_decoder_top hncr_checker u_hncr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

// File: tb/tb_html_numeric_char_ref_decoder_top.sv
// Self-checking stream testbench for the HTML numeric character reference decoder.
`timescale 1ns / 1ps

module tb_html_numeric_char_ref_decoder_top;

	localparam int CLK_HALF = 10;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES = 120;
	localparam int IDLE_PCT = 11;
	localparam int LEGACY_N = 28;

	typedef enum logic [1:0] {AT_START, AFTER_HASH, IN_DIGITS} parse_phase_t;

	typedef struct packed {
		logic [hncr_pkg::CP_W-1:0] code_point;
		logic end_of_input;
	} cp_beat_t;

	localparam logic [0:LEGACY_N-1][7:0] LEGACY_FROM = {
		8'h00, 8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
		8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
		8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
	};
	localparam logic [0:LEGACY_N-1][15:0] LEGACY_TO = {
		16'hFFFD, 16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020,
		16'h2021, 16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D,
		16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
	};
	localparam logic [0:5][hncr_pkg::CP_W-1:0] STOP_SET = {
		hncr_pkg::CP_TAB, hncr_pkg::CP_LF, hncr_pkg::CP_FF, hncr_pkg::CP_SPACE,
		hncr_pkg::CP_LT, hncr_pkg::CP_AMP
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [0:0]  cfg_addr = hncr_pkg::REG_EXTRA_STOP_ENABLE;
	logic [20:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;

	bit                        stop_en = 1'b0;
	logic [hncr_pkg::CP_W-1:0] stop_char = '0;
	parse_phase_t              phase_q = AT_START;
	bit                        hex_q = 1'b0;
	logic [hncr_pkg::CP_W-1:0] accum_q = '0;
	bit                        seen_q = 1'b0;

	hncr_pkg::result_t expected_results[$];
	cp_beat_t          cp_feed[$];

	int mismatches = 0;
	int cycle_count = 0;
	bit in_taken = 1'b0;
	bit no_idle = 1'b0;
	bit want_hold = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	html_numeric_char_ref_decoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic int digit_value(logic [hncr_pkg::CP_W-1:0] cp, logic eoi, bit hex);
		if (eoi)
			return -1;
		if (cp >= hncr_pkg::CP_DIGIT_0 && cp <= hncr_pkg::CP_DIGIT_9)
			return int'(cp - hncr_pkg::CP_DIGIT_0);
		if (hex && cp >= hncr_pkg::CP_LOWER_A && cp <= hncr_pkg::CP_LOWER_F)
			return int'(cp - hncr_pkg::CP_LOWER_A) + 10;
		if (hex && cp >= hncr_pkg::CP_UPPER_A && cp <= hncr_pkg::CP_UPPER_F)
			return int'(cp - hncr_pkg::CP_UPPER_A) + 10;
		return -1;
	endfunction

	function automatic bit is_disallowed(logic [hncr_pkg::CP_W-1:0] v);
		return (v >= 21'h01 && v <= 21'h08) || v == 21'h0B ||
			(v >= 21'h0E && v <= 21'h1F) ||
			(v >= hncr_pkg::CP_DEL && v <= hncr_pkg::CP_C1_HI) ||
			(v >= hncr_pkg::CP_NONCHAR_LO && v <= hncr_pkg::CP_NONCHAR_HI) ||
			((v & hncr_pkg::CP_NONCHAR_MASK) == hncr_pkg::CP_NONCHAR_MASK);
	endfunction

	function automatic bit is_stop(logic [hncr_pkg::CP_W-1:0] cp);
		return cp == hncr_pkg::CP_TAB || cp == hncr_pkg::CP_LF || cp == hncr_pkg::CP_FF ||
			cp == hncr_pkg::CP_SPACE || cp == hncr_pkg::CP_LT || cp == hncr_pkg::CP_AMP;
	endfunction

	task automatic close_reference(logic [hncr_pkg::STATUS_W-1:0] st,
			logic [hncr_pkg::CP_W-1:0] ch, bit gb, bit ms);
		hncr_pkg::result_t r;
		r.status = st;
		r.char_out = ch;
		r.given_back = gb;
		r.missing_semicolon = ms;
		expected_results = {expected_results, r};
		phase_q = AT_START;
		hex_q = 1'b0;
		accum_q = '0;
		seen_q = 1'b0;
	endtask

	task automatic close_number(logic [hncr_pkg::CP_W-1:0] cp, logic eoi);
		bit gb;
		logic [hncr_pkg::CP_W-1:0] v;
		gb = eoi || cp != hncr_pkg::CP_SEMI;
		v = accum_q;
		if (!seen_q) begin
			close_reference(hncr_pkg::ST_NO_DIGITS, '0, 1'b1, 1'b0);
			return;
		end
		for (int i = 0; i < LEGACY_N; i++) begin
			if (v == hncr_pkg::CP_W'(LEGACY_FROM[i])) begin
				close_reference(hncr_pkg::ST_REMAPPED, hncr_pkg::CP_W'(LEGACY_TO[i]), gb, gb);
				return;
			end
		end
		if ((v >= hncr_pkg::CP_SURR_LO && v <= hncr_pkg::CP_SURR_HI) || v > hncr_pkg::CP_MAX)
			close_reference(hncr_pkg::ST_REPLACED, hncr_pkg::CP_REPLACEMENT, gb, gb);
		else if (is_disallowed(v))
			close_reference(hncr_pkg::ST_DISALLOWED, v, gb, gb);
		else
			close_reference(hncr_pkg::ST_OK, v, gb, gb);
	endtask

	task automatic number_beat(logic [hncr_pkg::CP_W-1:0] cp, logic eoi);
		int d;
		logic [31:0] nv;
		d = digit_value(cp, eoi, hex_q);
		if (d >= 0) begin
			nv = 32'(accum_q) * (hex_q ? 32'd16 : 32'd10) + 32'(d);
			accum_q = (accum_q >= hncr_pkg::ACC_SAT || nv >= 32'(hncr_pkg::ACC_SAT)) ?
				hncr_pkg::ACC_SAT : nv[hncr_pkg::CP_W-1:0];
			seen_q = 1'b1;
			phase_q = IN_DIGITS;
		end else begin
			close_number(cp, eoi);
		end
	endtask

	task automatic decode_beat(logic [hncr_pkg::CP_W-1:0] cp, logic eoi);
		case (phase_q)
			AFTER_HASH: begin
				if (!eoi && (cp == hncr_pkg::CP_LOWER_X || cp == hncr_pkg::CP_UPPER_X)) begin
					hex_q = 1'b1;
					phase_q = IN_DIGITS;
				end else begin
					hex_q = 1'b0;
					phase_q = IN_DIGITS;
					number_beat(cp, eoi);
				end
			end
			IN_DIGITS: begin
				number_beat(cp, eoi);
			end
			default: begin
				if (eoi || (stop_en && cp == stop_char) || is_stop(cp)) begin
					close_reference(hncr_pkg::ST_STOP, '0, 1'b1, 1'b0);
				end else if (cp == hncr_pkg::CP_HASH) begin
					phase_q = AFTER_HASH;
					hex_q = 1'b0;
					accum_q = '0;
					seen_q = 1'b0;
				end else begin
					close_reference(hncr_pkg::ST_NOT_NUMERIC, '0, 1'b1, 1'b0);
				end
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		hncr_pkg::result_t want;
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_html_numeric_char_ref_decoder_top NOT OK");
			$finish;
		end else begin
			in_taken = arst_n && s_tvalid && s_tready;
			if (arst_n && cfg_wen) begin
				case (cfg_addr)
					hncr_pkg::REG_EXTRA_STOP_ENABLE: stop_en = cfg_wdata[0];
					hncr_pkg::REG_EXTRA_STOP_CHAR: stop_char = cfg_wdata;
					default: ;
				endcase
			end
			if (in_taken)
				decode_beat(s_tdata[hncr_pkg::CP_W-1:0], s_tlast);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result beat", 32'(m_tdata), 32'h0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", 32'(m_tuser), 32'(want.status));
					if (m_tdata[20:0] !== want.char_out)
						report_mismatch("char_out", 32'(m_tdata[20:0]), 32'(want.char_out));
					if (m_tdata[21] !== want.given_back)
						report_mismatch("given_back", 32'(m_tdata[21]), 32'(want.given_back));
					if (m_tdata[22] !== want.missing_semicolon)
						report_mismatch("missing_semicolon", 32'(m_tdata[22]),
							32'(want.missing_semicolon));
				end
			end
		end
	end

	always @(negedge clk) begin
		cp_beat_t beat;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (cp_feed.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
				beat = cp_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, beat.code_point};
				s_tlast <= beat.end_of_input;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// The long hold lets the sender keep offering beats until the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (want_hold && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [20:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_extra_stop(bit en, logic [hncr_pkg::CP_W-1:0] ch);
		write_reg(hncr_pkg::REG_EXTRA_STOP_ENABLE, 21'(en));
		write_reg(hncr_pkg::REG_EXTRA_STOP_CHAR, ch);
	endtask

	task automatic push_cp(logic [hncr_pkg::CP_W-1:0] cp);
		cp_beat_t b;
		b.code_point = cp;
		b.end_of_input = 1'b0;
		cp_feed = {cp_feed, b};
	endtask

	task automatic push_eoi();
		cp_beat_t b;
		b.code_point = hncr_pkg::CP_W'($urandom_range(0, hncr_pkg::CP_MAX));
		b.end_of_input = 1'b1;
		cp_feed = {cp_feed, b};
	endtask

	task automatic push_number(logic [31:0] v, bit hex);
		int digs[12];
		int n;
		n = 0;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) push_cp(hncr_pkg::CP_DIGIT_0);
		do begin
			digs[n] = hex ? int'(v % 16) : int'(v % 10);
			v = hex ? v / 16 : v / 10;
			n++;
		end while (v != 0);
		for (int k = n - 1; k >= 0; k--) begin
			if (digs[k] < 10)
				push_cp(hncr_pkg::CP_DIGIT_0 + hncr_pkg::CP_W'(digs[k]));
			else if ($urandom_range(0, 1))
				push_cp(hncr_pkg::CP_UPPER_A + hncr_pkg::CP_W'(digs[k] - 10));
			else
				push_cp(hncr_pkg::CP_LOWER_A + hncr_pkg::CP_W'(digs[k] - 10));
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 8))
			0: return 32'(LEGACY_FROM[$urandom_range(0, LEGACY_N - 1)]);
			1: return $urandom_range(hncr_pkg::CP_SURR_LO, hncr_pkg::CP_SURR_HI);
			2: return $urandom_range(32'h110000, 32'hFFFFFFFF);
			3: begin
				case ($urandom_range(0, 3))
					0: return 32'(hncr_pkg::CP_MAX);
					1: return 32'(hncr_pkg::ACC_SAT);
					2: return 32'h0000D7FF;
					default: return 32'h0000E000;
				endcase
			end
			4: begin
				if ($urandom_range(0, 1))
					return $urandom_range(hncr_pkg::CP_NONCHAR_LO, hncr_pkg::CP_NONCHAR_HI);
				return (32'($urandom_range(0, 16)) << 16) | 32'hFFFE |
					32'($urandom_range(0, 1));
			end
			5: begin
				if ($urandom_range(0, 1))
					return $urandom_range(1, 32'h1F);
				return $urandom_range(hncr_pkg::CP_DEL, hncr_pkg::CP_C1_HI);
			end
			6: return 32'h0;
			7: return $urandom_range(0, 255);
			default: return $urandom_range(0, hncr_pkg::CP_MAX);
		endcase
	endfunction

	// Mostly well-formed references with random values, the rest stops, junk and cut-off ones.
	task automatic queue_random_refs(int count, logic [hncr_pkg::CP_W-1:0] extra_char);
		int base;
		int kind;
		int term;
		bit hex;
		base = cp_feed.size();
		while (cp_feed.size() < base + count) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				hex = $urandom_range(0, 1);
				push_cp(hncr_pkg::CP_HASH);
				if (hex)
					push_cp($urandom_range(0, 1) ? hncr_pkg::CP_UPPER_X : hncr_pkg::CP_LOWER_X);
				push_number(pick_value(), hex);
				term = $urandom_range(0, 99);
				if (term < 65)
					push_cp(hncr_pkg::CP_SEMI);
				else if (term < 80)
					push_eoi();
				else if (term < 90)
					push_cp(STOP_SET[$urandom_range(0, 5)]);
				else
					push_cp(hncr_pkg::CP_W'($urandom_range(0, hncr_pkg::CP_MAX)));
			end else if (kind < 80) begin
				term = $urandom_range(0, 7);
				if (term < 6)
					push_cp(STOP_SET[term]);
				else if (term == 6)
					push_eoi();
				else
					push_cp(extra_char);
			end else if (kind < 88) begin
				push_cp(hncr_pkg::CP_W'($urandom_range(0, hncr_pkg::CP_MAX)));
			end else begin
				push_cp(hncr_pkg::CP_HASH);
				if ($urandom_range(0, 1))
					push_cp($urandom_range(0, 1) ? hncr_pkg::CP_UPPER_X : hncr_pkg::CP_LOWER_X);
				term = $urandom_range(0, 2);
				if (term == 0)
					push_cp(hncr_pkg::CP_SEMI);
				else if (term == 1)
					push_eoi();
				else
					push_cp(hncr_pkg::CP_W'($urandom_range(0, hncr_pkg::CP_MAX)));
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (!(cp_feed.size() == 0 && (!s_tvalid || in_taken) &&
			expected_results.size() == 0));
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [hncr_pkg::CP_W-1:0] ch;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_extra_stop(1'b0, '0);
		foreach (STOP_SET[i])
			push_cp(STOP_SET[i]);
		push_eoi();
		push_cp(hncr_pkg::CP_LOWER_A);
		push_cp(hncr_pkg::CP_HASH);
		push_cp(hncr_pkg::CP_SEMI);
		push_cp(hncr_pkg::CP_HASH);
		push_cp(hncr_pkg::CP_UPPER_X);
		push_eoi();
		push_cp(hncr_pkg::CP_HASH);
		push_cp(hncr_pkg::CP_DIGIT_0);
		push_cp(hncr_pkg::CP_SEMI);
		push_cp(hncr_pkg::CP_HASH);
		push_cp(hncr_pkg::CP_LOWER_X);
		push_cp(hncr_pkg::CP_DIGIT_9);
		push_cp(hncr_pkg::CP_UPPER_F);
		push_cp(hncr_pkg::CP_LT);
		push_cp(hncr_pkg::CP_HASH);
		push_cp(hncr_pkg::CP_DIGIT_0 + 21'd1);
		push_eoi();
		wait_drained();

		set_extra_stop(1'b1, hncr_pkg::CP_MAX);
		queue_random_refs(150, hncr_pkg::CP_MAX);
		wait_drained();

		set_extra_stop(1'b1, hncr_pkg::CP_HASH);
		queue_random_refs(60, hncr_pkg::CP_HASH);
		wait_drained();

		set_extra_stop(1'b1, '0);
		queue_random_refs(120, '0);
		want_hold <= 1'b1;
		wait_drained();

		case ($urandom_range(0, 3))
			0: ch = hncr_pkg::CP_LOWER_X;
			1: ch = hncr_pkg::CP_SEMI;
			2: ch = hncr_pkg::CP_DIGIT_0 + 21'd5;
			default: ch = hncr_pkg::CP_W'($urandom_range(0, hncr_pkg::CP_MAX));
		endcase
		set_extra_stop(1'b1, ch);
		no_idle <= 1'b1;
		queue_random_refs(150, ch);
		wait_drained();
		no_idle <= 1'b0;

		ch = hncr_pkg::CP_W'($urandom_range(0, hncr_pkg::CP_MAX));
		set_extra_stop(1'b0, ch);
		queue_random_refs(100, ch);
		wait_drained();

		if (mismatches == 0)
			$display("tb_html_numeric_char_ref_decoder_top OK");
		else
			$display("tb_html_numeric_char_ref_decoder_top NOT OK");
		$finish;
	end

endmodule
